// File: sv/ajf_pkg.sv
// ajf_pkg: shared types, code point constants and the joining type lookup
// for the arabic joining form classifier; used by every module of the block
package ajf_pkg;

  localparam int unsigned CpW = 21;

  typedef logic [CpW-1:0] cp_t;

  typedef enum logic [1:0] {
    JT_NONE  = 2'd0,
    JT_RIGHT = 2'd1,
    JT_DUAL  = 2'd2,
    JT_CAUSE = 2'd3
  } join_type_e;

  typedef enum logic [1:0] {
    FORM_ISOL = 2'd0,
    FORM_INIT = 2'd1,
    FORM_MEDI = 2'd2,
    FORM_FINA = 2'd3
  } form_e;

  typedef struct packed {
    cp_t  code_point;
    logic last_in_run;
  } in_item_t;

  typedef struct packed {
    cp_t   char_value;
    form_e form;
    logic  run_end;
  } out_item_t;

  // up to two results per request, first one always written first
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } q_push_t;

  localparam cp_t CpAlefMadda   = 21'h000622;
  localparam cp_t CpAlefHamzaLo = 21'h000625;
  localparam cp_t CpAlef        = 21'h000627;
  localparam cp_t CpBeh         = 21'h000628;
  localparam cp_t CpTehMarbuta  = 21'h000629;
  localparam cp_t CpTeh         = 21'h00062A;
  localparam cp_t CpKhah        = 21'h00062E;
  localparam cp_t CpDal         = 21'h00062F;
  localparam cp_t CpZain        = 21'h000632;
  localparam cp_t CpSeen        = 21'h000633;
  localparam cp_t CpGhain       = 21'h00063A;
  localparam cp_t CpTatweel     = 21'h000640;
  localparam cp_t CpFeh         = 21'h000641;
  localparam cp_t CpHeh         = 21'h000647;
  localparam cp_t CpWaw         = 21'h000648;
  localparam cp_t CpAlefMaksura = 21'h000649;
  localparam cp_t CpYeh         = 21'h00064A;
  localparam cp_t CpMongLo      = 21'h001820;
  localparam cp_t CpMongHi      = 21'h001842;

  function automatic join_type_e join_type_of(cp_t cp);
    join_type_e jt;
    jt = JT_NONE;
    if ((cp >= CpAlefMadda && cp <= CpAlefHamzaLo) || cp == CpAlef ||
        (cp >= CpDal && cp <= CpZain) || cp == CpWaw) begin
      jt = JT_RIGHT;
    end else if (cp == CpBeh || (cp >= CpTeh && cp <= CpKhah) ||
                 (cp >= CpSeen && cp <= CpGhain) || (cp >= CpFeh && cp <= CpHeh) ||
                 cp == CpAlefMaksura || cp == CpYeh ||
                 (cp >= CpMongLo && cp <= CpMongHi)) begin
      jt = JT_DUAL;
    end else if (cp == CpTatweel) begin
      jt = JT_CAUSE;
    end
    return jt;
  endfunction

  function automatic logic joins_forward(join_type_e t);
    return (t == JT_DUAL) || (t == JT_CAUSE);
  endfunction

  function automatic logic joins_backward(join_type_e t);
    return t != JT_NONE;
  endfunction

  function automatic form_e pick_form(join_type_e t, logic p, logic n);
    form_e f;
    f = FORM_ISOL;
    if (t == JT_NONE) begin
      f = FORM_ISOL;
    end else if (p && n) begin
      f = FORM_MEDI;
    end else if (p) begin
      f = FORM_FINA;
    end else if (n && t != JT_RIGHT) begin
      f = FORM_INIT;
    end
    return f;
  endfunction

endpackage

// File: sv/ajf_front.sv
// ajf_front: accepts code points, classifies them and holds one back;
// pushes zero, one or two finished results into the queue. needs ajf_pkg
module ajf_front import ajf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output q_push_t  push_o
);

  logic       held_valid_q, held_valid_d;
  cp_t        held_char_q, held_char_d;
  join_type_e held_type_q, held_type_d;
  logic       before_joins_q, before_joins_d;

  join_type_e cur_type;
  logic       cur_prev;
  out_item_t  held_res, last_res;

  always_comb begin
    cur_type = join_type_of(item_i.code_point);
    cur_prev = held_valid_q && joins_forward(held_type_q);

    held_res.char_value = held_char_q;
    held_res.form       = pick_form(held_type_q, before_joins_q, joins_backward(cur_type));
    held_res.run_end    = 1'b0;

    last_res.char_value = item_i.code_point;
    last_res.form       = pick_form(cur_type, cur_prev, 1'b0);
    last_res.run_end    = 1'b1;

    push_o.cnt    = 2'd0;
    push_o.first  = held_valid_q ? held_res : last_res;
    push_o.second = last_res;
    if (accept_i) begin
      push_o.cnt = 2'({1'b0, held_valid_q}) + 2'({1'b0, item_i.last_in_run});
    end

    held_valid_d   = held_valid_q;
    held_char_d    = held_char_q;
    held_type_d    = held_type_q;
    before_joins_d = before_joins_q;
    if (accept_i) begin
      // the last item of a run leaves nothing held
      held_valid_d   = !item_i.last_in_run;
      held_char_d    = item_i.last_in_run ? '0 : item_i.code_point;
      held_type_d    = item_i.last_in_run ? JT_NONE : cur_type;
      before_joins_d = item_i.last_in_run ? 1'b0 : cur_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q   <= 1'b0;
      held_char_q    <= '0;
      held_type_q    <= JT_NONE;
      before_joins_q <= 1'b0;
    end else begin
      held_valid_q   <= held_valid_d;
      held_char_q    <= held_char_d;
      held_type_q    <= held_type_d;
      before_joins_q <= before_joins_d;
    end
  end

endmodule

// File: sv/ajf_queue.sv
// ajf_queue: small result queue between front and back, up to two writes and one
// read per cycle; flop storage read only at the head. needs ajf_pkg
module ajf_queue import ajf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_push_t   push_i,
  input  logic      pop_i,
  output logic      room_low_o,
  output logic      head_valid_o,
  output out_item_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  out_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CntW-1:0] count_q, count_d;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_nx = next_ptr(wr_ptr_q);
    unique case (push_i.cnt)
      2'd0:    wr_ptr_d = wr_ptr_q;
      2'd1:    wr_ptr_d = wr_ptr_nx;
      default: wr_ptr_d = next_ptr(wr_ptr_nx);
    endcase
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop_i);
  end

  assign room_low_o   = count_q > CntW'(DEPTH - 2);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) + 32'(push_i.cnt)) <= DEPTH)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue underflow");
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd3)
    else $error("more than two results pushed");
`endif

endmodule

// File: sv/ajf_back.sv
// ajf_back: output register that drains the result queue one entry a cycle
// and holds its result while the receiver stalls. needs ajf_pkg
module ajf_back import ajf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  out_item_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // refill when the register is empty or being taken this cycle
  assign pop_o = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_item_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: sv/arabic_joining_form_classifier_core.sv
// arabic_joining_form_classifier_core: top level of the joining form block
// depends on ajf_pkg, ajf_front, ajf_queue and ajf_back
//
// usage: code points of a run enter on in_item_i with in_valid_i; a request
// is taken at a rising edge with in_valid_i high and in_stall_o low.
// results leave on out_item_o with out_valid_o, taken when out_stall_i is low.
// one code point is held back until the next one shows its joining type, so
// a request normally releases the result of the one before it; the request
// marked last_in_run releases both the held result and its own (run_end set).
// throughput: one request per cycle while in_stall_o is low; a run of n code
// points gives n results. a released result is written into the result queue
// and then into the output register, behind anything already queued.
// the result queue holds QueueDepth entries; in_stall_o rises while fewer
// than two entries are free, so a stalled receiver backs up into the input.
// reset clears the held code point, the queue count and the output valid flag;
// no results are pending after reset.
module arabic_joining_form_classifier_core import ajf_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      accept;
  q_push_t   push;
  logic      pop;
  logic      room_low;
  logic      head_valid;
  out_item_t head;

  assign in_stall_o = room_low;
  assign accept     = in_valid_i && !room_low;

  ajf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push)
  );

  ajf_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .room_low_o   (room_low),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ajf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
